### hdl/ntt_conv_pkg.sv
// ----------------------------------------------------------------------------
// ntt_conv_pkg
// Constants, twiddle tables and modular helpers for the NTT convolution block.
// ----------------------------------------------------------------------------
package ntt_conv_pkg;

  localparam int unsigned ValW      = 30;
  localparam int unsigned LenW      = 6;
  localparam int unsigned MaxTerms  = 32;
  localparam int unsigned XformMax  = 64;
  localparam int unsigned XformLog  = 6;
  localparam int unsigned TwDepth   = XformMax / 2;

  localparam logic [29:0] Modulus   = 30'd998244353;
  localparam logic [63:0] Modulus64 = 64'd998244353;
  localparam logic [31:0] Modulus2  = 32'd1996488706;
  localparam logic [63:0] RootOdd   = 64'd119;
  localparam logic [63:0] Generator = 64'd3;

  // barrett constant floor(2^60 / p), fits in 31 bits
  localparam logic [30:0] BarrettMu = 31'((64'd1 << 60) / Modulus64);

  typedef logic [29:0] tw_tbl_t [TwDepth];
  typedef logic [29:0] kinv_tbl_t [XformLog + 1];

  function automatic logic [29:0] pow_mod(input logic [63:0] base, input logic [63:0] expo);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] e;
    r = 64'd1;
    b = base % Modulus64;
    e = expo;
    for (int i = 0; i < 64; i++) begin
      if (e[0]) begin
        r = (r * b) % Modulus64;
      end
      b = (b * b) % Modulus64;
      e = e >> 1;
    end
    return r[29:0];
  endfunction

  function automatic tw_tbl_t build_tw(input logic inv);
    tw_tbl_t     tbl;
    logic [29:0] root;
    root = pow_mod(Generator, RootOdd << (23 - XformLog));
    if (inv) begin
      root = pow_mod({34'd0, root}, Modulus64 - 64'd2);
    end
    for (int t = 0; t < TwDepth; t++) begin
      tbl[t] = pow_mod({34'd0, root}, 64'(t));
    end
    return tbl;
  endfunction

  function automatic kinv_tbl_t build_kinv();
    kinv_tbl_t tbl;
    for (int e = 0; e <= XformLog; e++) begin
      tbl[e] = pow_mod(64'd1 << e, Modulus64 - 64'd2);
    end
    return tbl;
  endfunction

  localparam tw_tbl_t   TwFwd = build_tw(1'b0);
  localparam tw_tbl_t   TwInv = build_tw(1'b1);
  localparam kinv_tbl_t KInv  = build_kinv();

  function automatic logic [29:0] mod_add(input logic [29:0] a, input logic [29:0] b);
    logic [30:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= {1'b0, Modulus}) ? 30'(s - {1'b0, Modulus}) : s[29:0];
  endfunction

  function automatic logic [29:0] mod_sub(input logic [29:0] a, input logic [29:0] b);
    logic [30:0] s;
    s = {1'b0, a} + {1'b0, Modulus} - {1'b0, b};
    return (a >= b) ? (a - b) : s[29:0];
  endfunction

endpackage

### hdl/ntt_polynomial_convolution_top.sv
// ----------------------------------------------------------------------------
// ntt_polynomial_convolution_top
// Polynomial product modulo 998244353 by forward NTT, pointwise product and
// inverse NTT, on one shared Barrett modular multiplier.
// ----------------------------------------------------------------------------
// Load accepts one coefficient word per cycle while start is high. The word that
// completes the load starts a run with busy high: a padding clear, then
// 3*(K/2)*log2(K) butterflies, a pointwise product for each of the K points
// and a scaled result per output term, where K is the power of two at least the
// product length. Every modular product of a butterfly, pointwise product or
// result goes through the one 32x32 multiplier (product, Barrett quotient
// estimate, quotient times p, correction), and writes use the single write port
// of each buffer. Results come out on valid_o one cycle each and the receiver cannot hold them off.
module ntt_polynomial_convolution_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [5:0]  cfg_wdata_i,
  input  logic        start,
  output logic        busy,
  input  logic [29:0] coeff_value_i,
  output logic        valid_o,
  output logic [29:0] product_value_o,
  output logic [5:0]  product_index_o,
  output logic        last_term_o
);

  localparam logic CfgFirst  = 1'b0;
  localparam logic CfgSecond = 1'b1;

  localparam logic [3:0] StLoad   = 4'd0;
  localparam logic [3:0] StClear  = 4'd1;
  localparam logic [3:0] StBfRd   = 4'd2;
  localparam logic [3:0] StBfMul  = 4'd3;
  localparam logic [3:0] StBfWlo  = 4'd4;
  localparam logic [3:0] StBfWhi  = 4'd5;
  localparam logic [3:0] StPwRd   = 4'd6;
  localparam logic [3:0] StPwMul  = 4'd7;
  localparam logic [3:0] StPwWr   = 4'd8;
  localparam logic [3:0] StOutRd  = 4'd9;
  localparam logic [3:0] StOutMul = 4'd10;
  localparam logic [3:0] StEmit   = 4'd11;
  localparam logic [3:0] StM1     = 4'd12;
  localparam logic [3:0] StM2     = 4'd13;
  localparam logic [3:0] StM3     = 4'd14;
  localparam logic [3:0] StM4     = 4'd15;

  localparam logic [1:0] PhFwdA = 2'd0;
  localparam logic [1:0] PhFwdB = 2'd1;
  localparam logic [1:0] PhInv  = 2'd2;

  logic [3:0]  state_q, state_d, ret_q, ret_d;
  logic [1:0]  ph_q, ph_d;
  logic [2:0]  s_q, s_d;
  logic [4:0]  bf_q, bf_d;
  logic [5:0]  idx_q, idx_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [5:0]  first_len_q, first_len_d, second_len_q, second_len_d;

  logic [29:0] ma_q, ma_d, mb_q, mb_d, x_q, x_d, mres_q, mres_d;
  logic [59:0] prod_q, prod_d;
  logic [30:0] qest_q, qest_d;
  logic [31:0] rem_q, rem_d;

  logic [29:0] mem_a [ntt_conv_pkg::XformMax];
  logic [29:0] mem_b [ntt_conv_pkg::XformMax];
  logic [29:0] a_lo_q, a_hi_q, b_lo_q, b_hi_q;

  logic        we_a, we_b;
  logic [5:0]  wa_addr, wb_addr, rd_lo, rd_hi;
  logic [29:0] wa_data, wb_data;

  logic [5:0]  n_len, m_len, plen, klast, lo_addr, hi_addr, half6;
  logic [6:0]  total, kval;
  logic [2:0]  logk;
  logic [4:0]  bf_last, hmask, jpos, tw_idx;
  logic [29:0] tw, in_val, u_sel, v_sel;
  logic        accept, sel_b, inv_ph;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  // length clamping and transform size
  always_comb begin
    if (first_len_q == 6'd0) begin
      n_len = 6'd1;
    end else if (first_len_q > 6'(ntt_conv_pkg::MaxTerms)) begin
      n_len = 6'(ntt_conv_pkg::MaxTerms);
    end else begin
      n_len = first_len_q;
    end
    if (second_len_q == 6'd0) begin
      m_len = 6'd1;
    end else if (second_len_q > 6'(ntt_conv_pkg::MaxTerms)) begin
      m_len = 6'(ntt_conv_pkg::MaxTerms);
    end else begin
      m_len = second_len_q;
    end
  end

  assign total = {1'b0, n_len} + {1'b0, m_len};
  assign plen  = 6'(total - 7'd1);

  always_comb begin
    priority if (plen <= 6'd1) begin
      logk = 3'd0;
    end else if (plen <= 6'd2) begin
      logk = 3'd1;
    end else if (plen <= 6'd4) begin
      logk = 3'd2;
    end else if (plen <= 6'd8) begin
      logk = 3'd3;
    end else if (plen <= 6'd16) begin
      logk = 3'd4;
    end else if (plen <= 6'd32) begin
      logk = 3'd5;
    end else begin
      logk = 3'd6;
    end
  end

  assign kval    = 7'd1 << logk;
  assign klast   = 6'(kval - 7'd1);
  assign bf_last = 5'((kval >> 1) - 7'd1);

  // butterfly addressing
  assign half6   = 6'd1 << (s_q - 3'd1);
  assign hmask   = 5'(half6 - 6'd1);
  assign jpos    = bf_q & hmask;
  assign lo_addr = {bf_q & ~hmask, 1'b0} | {1'b0, jpos};
  assign hi_addr = lo_addr | half6;
  assign tw_idx  = 5'(jpos << (3'd6 - s_q));
  assign inv_ph  = (ph_q == PhInv);
  assign sel_b   = (ph_q == PhFwdB);
  assign tw      = inv_ph ? ntt_conv_pkg::TwInv[tw_idx] : ntt_conv_pkg::TwFwd[tw_idx];
  assign u_sel   = sel_b ? b_lo_q : a_lo_q;
  assign v_sel   = sel_b ? b_hi_q : a_hi_q;

  assign in_val  = (coeff_value_i >= ntt_conv_pkg::Modulus) ?
                   (coeff_value_i - ntt_conv_pkg::Modulus) : coeff_value_i;
  assign accept  = start && (state_q == StLoad);
  assign busy    = (state_q != StLoad);

  assign rd_lo = (state_q == StBfRd) ? lo_addr : idx_q;
  assign rd_hi = hi_addr;

  // shared multiplier operand select
  always_comb begin
    unique case (state_q)
      StM2: begin
        mul_a = {1'b0, prod_q[59:29]};
        mul_b = {1'b0, ntt_conv_pkg::BarrettMu};
      end
      StM3: begin
        mul_a = {1'b0, qest_q};
        mul_b = {2'b0, ntt_conv_pkg::Modulus};
      end
      default: begin
        mul_a = {2'b0, ma_q};
        mul_b = {2'b0, mb_q};
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    state_d      = state_q;
    ret_d        = ret_q;
    ph_d         = ph_q;
    s_d          = s_q;
    bf_d         = bf_q;
    idx_d        = idx_q;
    cnt_d        = cnt_q;
    first_len_d  = first_len_q;
    second_len_d = second_len_q;
    ma_d         = ma_q;
    mb_d         = mb_q;
    x_d          = x_q;
    mres_d       = mres_q;
    prod_d       = prod_q;
    qest_d       = qest_q;
    rem_d        = rem_q;
    we_a         = 1'b0;
    we_b         = 1'b0;
    wa_addr      = idx_q;
    wb_addr      = idx_q;
    wa_data      = '0;
    wb_data      = '0;

    unique case (state_q)
      StLoad: begin
        if (accept) begin
          if (cnt_q < {1'b0, n_len}) begin
            we_a    = 1'b1;
            wa_addr = cnt_q[5:0];
            wa_data = in_val;
          end else begin
            we_b    = 1'b1;
            wb_addr = 6'(cnt_q - {1'b0, n_len});
            wb_data = in_val;
          end
          if (cnt_q + 7'd1 == total) begin
            cnt_d   = '0;
            idx_d   = '0;
            state_d = StClear;
          end else begin
            cnt_d = cnt_q + 7'd1;
          end
        end
      end
      StClear: begin
        we_a    = (idx_q >= n_len);
        we_b    = (idx_q >= m_len);
        if (idx_q == klast) begin
          idx_d = '0;
          ph_d  = PhFwdA;
          s_d   = logk;
          bf_d  = '0;
          state_d = (logk == 3'd0) ? StPwRd : StBfRd;
        end else begin
          idx_d = idx_q + 6'd1;
        end
      end
      StBfRd: begin
        state_d = StBfMul;
      end
      StBfMul: begin
        if (inv_ph) begin
          x_d  = u_sel;
          ma_d = v_sel;
        end else begin
          x_d  = ntt_conv_pkg::mod_add(u_sel, v_sel);
          ma_d = ntt_conv_pkg::mod_sub(u_sel, v_sel);
        end
        mb_d    = tw;
        ret_d   = StBfWlo;
        state_d = StM1;
      end
      StBfWlo: begin
        we_a    = !sel_b;
        we_b    = sel_b;
        wa_addr = lo_addr;
        wb_addr = lo_addr;
        wa_data = inv_ph ? ntt_conv_pkg::mod_add(x_q, mres_q) : x_q;
        wb_data = wa_data;
        state_d = StBfWhi;
      end
      StBfWhi: begin
        we_a    = !sel_b;
        we_b    = sel_b;
        wa_addr = hi_addr;
        wb_addr = hi_addr;
        wa_data = inv_ph ? ntt_conv_pkg::mod_sub(x_q, mres_q) : mres_q;
        wb_data = wa_data;
        state_d = StBfRd;
        if (bf_q == bf_last) begin
          bf_d = '0;
          if (inv_ph) begin
            if (s_q == logk) begin
              idx_d   = '0;
              state_d = StOutRd;
            end else begin
              s_d = s_q + 3'd1;
            end
          end else if (s_q == 3'd1) begin
            if (sel_b) begin
              idx_d   = '0;
              state_d = StPwRd;
            end else begin
              ph_d = PhFwdB;
              s_d  = logk;
            end
          end else begin
            s_d = s_q - 3'd1;
          end
        end else begin
          bf_d = bf_q + 5'd1;
        end
      end
      StPwRd: begin
        state_d = StPwMul;
      end
      StPwMul: begin
        ma_d    = a_lo_q;
        mb_d    = b_lo_q;
        ret_d   = StPwWr;
        state_d = StM1;
      end
      StPwWr: begin
        we_a    = 1'b1;
        wa_data = mres_q;
        if (idx_q == klast) begin
          idx_d = '0;
          ph_d  = PhInv;
          s_d   = 3'd1;
          bf_d  = '0;
          state_d = (logk == 3'd0) ? StOutRd : StBfRd;
        end else begin
          idx_d   = idx_q + 6'd1;
          state_d = StPwRd;
        end
      end
      StOutRd: begin
        state_d = StOutMul;
      end
      StOutMul: begin
        ma_d    = a_lo_q;
        mb_d    = ntt_conv_pkg::KInv[logk];
        ret_d   = StEmit;
        state_d = StM1;
      end
      StEmit: begin
        if (idx_q == 6'(plen - 6'd1)) begin
          idx_d   = '0;
          state_d = StLoad;
        end else begin
          idx_d   = idx_q + 6'd1;
          state_d = StOutRd;
        end
      end
      StM1: begin
        prod_d  = mul_p[59:0];
        state_d = StM2;
      end
      StM2: begin
        qest_d  = mul_p[61:31];
        state_d = StM3;
      end
      StM3: begin
        rem_d   = prod_q[31:0] - mul_p[31:0];
        state_d = StM4;
      end
      StM4: begin
        if (rem_q >= ntt_conv_pkg::Modulus2) begin
          mres_d = 30'(rem_q - ntt_conv_pkg::Modulus2);
        end else if (rem_q >= {2'b0, ntt_conv_pkg::Modulus}) begin
          mres_d = 30'(rem_q - {2'b0, ntt_conv_pkg::Modulus});
        end else begin
          mres_d = rem_q[29:0];
        end
        state_d = ret_q;
      end
      default: begin
        state_d = StLoad;
      end
    endcase

    if (cfg_we_i) begin
      cnt_d = '0;
      unique case (cfg_idx_i)
        CfgFirst:  first_len_d  = cfg_wdata_i;
        CfgSecond: second_len_d = cfg_wdata_i;
        default:   first_len_d  = first_len_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StLoad;
      ret_q        <= StLoad;
      ph_q         <= PhFwdA;
      s_q          <= '0;
      bf_q         <= '0;
      idx_q        <= '0;
      cnt_q        <= '0;
      first_len_q  <= 6'd1;
      second_len_q <= 6'd1;
    end else begin
      state_q      <= state_d;
      ret_q        <= ret_d;
      ph_q         <= ph_d;
      s_q          <= s_d;
      bf_q         <= bf_d;
      idx_q        <= idx_d;
      cnt_q        <= cnt_d;
      first_len_q  <= first_len_d;
      second_len_q <= second_len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ma_q   <= ma_d;
    mb_q   <= mb_d;
    x_q    <= x_d;
    mres_q <= mres_d;
    prod_q <= prod_d;
    qest_q <= qest_d;
    rem_q  <= rem_d;
  end

  // coefficient buffers
  always_ff @(posedge clk_i) begin
    if (we_a) begin
      mem_a[wa_addr] <= wa_data;
    end
    a_lo_q <= mem_a[rd_lo];
    a_hi_q <= mem_a[rd_hi];
  end

  always_ff @(posedge clk_i) begin
    if (we_b) begin
      mem_b[wb_addr] <= wb_data;
    end
    b_lo_q <= mem_b[rd_lo];
    b_hi_q <= mem_b[rd_hi];
  end

  assign valid_o         = (state_q == StEmit);
  assign product_value_o = mres_q;
  assign product_index_o = idx_q;
  assign last_term_o     = (idx_q == 6'(plen - 6'd1));

endmodule

### test/tb_ntt_conv_regs_pkg.sv
// ----------------------------------------------------------------------------
// tb_ntt_conv_regs_pkg
// Configuration register indexes shared by the testbench and its checker.
// ----------------------------------------------------------------------------
package tb_ntt_conv_regs_pkg;

  typedef enum logic {
    RegFirstLen  = 1'b0,
    RegSecondLen = 1'b1
  } cfg_reg_e;

endpackage

### test/ntt_conv_checker.sv
// ----------------------------------------------------------------------------
// ntt_conv_checker
// Watches the config, coefficient and product channels of the NTT convolution
// block, forms each expected product by direct convolution modulo p and
// compares every product word against it in order.
// ----------------------------------------------------------------------------
module ntt_conv_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [5:0]  cfg_wdata_i,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [29:0] coeff_value_i,
  input  logic        valid_i,
  input  logic [29:0] product_value_i,
  input  logic [5:0]  product_index_i,
  input  logic        last_term_i,
  output int          mismatches_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [29:0] value;
    logic [5:0]  index;
    logic        last;
  } product_word_t;

  product_word_t expected_products[$];
  logic [5:0]    first_len_reg, second_len_reg;
  logic [29:0]   first_coeffs[ntt_conv_pkg::MaxTerms];
  logic [29:0]   second_coeffs[ntt_conv_pkg::MaxTerms];
  int            loaded;

  assign pending_o = expected_products.size();

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches_o++;
  endtask

  function automatic int clamp_len(logic [5:0] raw);
    if (raw == 0) return 1;
    if (raw > ntt_conv_pkg::MaxTerms) return ntt_conv_pkg::MaxTerms;
    return raw;
  endfunction

  task automatic expect_product(int n, int m);
    longint unsigned acc[ntt_conv_pkg::XformMax];
    product_word_t   w;
    int              plen;
    plen = n + m - 1;
    foreach (acc[i]) acc[i] = 0;
    for (int i = 0; i < n; i++)
      for (int j = 0; j < m; j++)
        acc[i+j] = (acc[i+j] + longint'(first_coeffs[i]) * longint'(second_coeffs[j]))
                   % longint'(ntt_conv_pkg::Modulus);
    for (int i = 0; i < plen; i++) begin
      w.value = acc[i][29:0];
      w.index = i[5:0];
      w.last  = (i == plen - 1);
      expected_products.push_back(w);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    int            n, m;
    logic [29:0]   v;
    product_word_t want;
    if (!rst_ni) begin
      first_len_reg  <= 6'd1;
      second_len_reg <= 6'd1;
      loaded         = 0;
      mismatches_o   = 0;
      expected_products.delete();
    end else begin
      if (valid_i) begin
        if (expected_products.size() == 0) begin
          report("unexpected word, index", product_index_i, -1);
        end else begin
          want = expected_products.pop_front();
          if (product_value_i !== want.value) report("value", product_value_i, want.value);
          if (product_index_i !== want.index) report("index", product_index_i, want.index);
          if (last_term_i !== want.last) report("last", last_term_i, want.last);
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == tb_ntt_conv_regs_pkg::RegFirstLen) first_len_reg <= cfg_wdata_i;
        else second_len_reg <= cfg_wdata_i;
        loaded = 0;
      end else if (start_i && !busy_i) begin
        n = clamp_len(first_len_reg);
        m = clamp_len(second_len_reg);
        v = (coeff_value_i >= ntt_conv_pkg::Modulus) ?
            coeff_value_i - ntt_conv_pkg::Modulus : coeff_value_i;
        if (loaded >= n + m) loaded = 0;
        if (loaded < n) first_coeffs[loaded] = v;
        else second_coeffs[loaded - n] = v;
        loaded++;
        if (loaded == n + m) begin
          loaded = 0;
          expect_product(n, m);
        end
      end
    end
  end

endmodule

### test/tb_ntt_polynomial_convolution_top.sv
// ----------------------------------------------------------------------------
// tb_ntt_polynomial_convolution_top
// Drives coefficient loads of many length settings into the NTT convolution
// block with random gaps and aborted loads; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_ntt_polynomial_convolution_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 40000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [5:0]  cfg_wdata_i = '0;
  logic        start = 1'b0;
  logic        busy;
  logic [29:0] coeff_value_i = '0;
  logic        valid_o;
  logic [29:0] product_value_o;
  logic [5:0]  product_index_o;
  logic        last_term_o;
  int          mismatches, pending;
  int          words_sent = 0;
  int          quiet_cycles = 0;
  bit          no_gaps = 0;

  ntt_polynomial_convolution_top dut (.*);

  ntt_conv_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .start_i(start), .busy_i(busy), .coeff_value_i,
    .valid_i(valid_o), .product_value_i(product_value_o),
    .product_index_i(product_index_o), .last_term_i(last_term_o),
    .mismatches_o(mismatches), .pending_o(pending)
  );

  initial forever #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if ((start && !busy) || valid_o || cfg_we_i) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > StallLimit) begin
      $display("ntt_polynomial_convolution_top verification failed");
      $finish;
    end
  end

  task automatic idle(int n);
    repeat (n) @(negedge clk_i) start = 1'b0;
  endtask

  task automatic random_gap();
    int r;
    r = $urandom_range(0, 19);
    if (no_gaps || r < 12) return;
    if (r < 18) idle($urandom_range(1, 3));
    else idle($urandom_range(20, 200));
  endtask

  function automatic logic [29:0] random_coeff();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return ntt_conv_pkg::Modulus - 1;
      2: return 30'($urandom_range(ntt_conv_pkg::Modulus, 30'h3fff_ffff));
      3: return 30'h3fff_ffff;
      default: return 30'($urandom());
    endcase
  endfunction

  task automatic put_word(logic [29:0] v);
    random_gap();
    @(negedge clk_i);
    start = 1'b1;
    coeff_value_i = v;
    do @(posedge clk_i); while (busy);
    words_sent++;
  endtask

  task automatic drain();
    idle(1);
    while (pending != 0 || busy) @(negedge clk_i);
    idle(30);
  endtask

  task automatic write_reg(tb_ntt_conv_regs_pkg::cfg_reg_e idx, logic [5:0] val);
    @(negedge clk_i);
    start = 1'b0;
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_lengths(logic [5:0] a, logic [5:0] b);
    drain();
    write_reg(tb_ntt_conv_regs_pkg::RegFirstLen, a);
    write_reg(tb_ntt_conv_regs_pkg::RegSecondLen, b);
  endtask

  function automatic int eff_len(logic [5:0] raw);
    return (raw == 0) ? 1 : (raw > ntt_conv_pkg::MaxTerms) ? ntt_conv_pkg::MaxTerms : raw;
  endfunction

  initial begin
    logic [5:0] a, b;
    int total;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    idle(3);

    // reset lengths 1 x 1, extremes of the word
    put_word('0); put_word(ntt_conv_pkg::Modulus - 1);
    put_word(30'h3fff_ffff); put_word(ntt_conv_pkg::Modulus);
    // zero lengths act as one
    set_lengths(6'd0, 6'd0);
    put_word(ntt_conv_pkg::Modulus - 1); put_word(ntt_conv_pkg::Modulus - 1);
    set_lengths(6'd2, 6'd3);
    repeat (5) put_word(random_coeff());
    // aborted load restarts at the first coefficient
    set_lengths(6'd3, 6'd2);
    put_word(30'd7); put_word(30'd9);
    write_reg(tb_ntt_conv_regs_pkg::RegSecondLen, 6'd2);
    repeat (5) put_word(random_coeff());
    // oversize lengths clamp to the maximum
    a = 6'd63;
    b = 6'd33;
    set_lengths(a, b);
    repeat (64) put_word(ntt_conv_pkg::Modulus - 1);

    while (words_sent < 450) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) != 0) begin
        if ($urandom_range(0, 9) == 0) begin
          a = 6'($urandom()); b = 6'($urandom());
        end else begin
          a = 6'($urandom_range(0, 8)); b = 6'($urandom_range(0, 8));
        end
        set_lengths(a, b);
      end
      total = eff_len(a) + eff_len(b);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, total - 1)) put_word(random_coeff());
        write_reg($urandom_range(0, 1) ? tb_ntt_conv_regs_pkg::RegFirstLen :
                                         tb_ntt_conv_regs_pkg::RegSecondLen,
                  $urandom_range(0, 1) ? a : b);
        drain();
        write_reg(tb_ntt_conv_regs_pkg::RegFirstLen, a);
        write_reg(tb_ntt_conv_regs_pkg::RegSecondLen, b);
      end
      repeat ($urandom_range(1, 3) * total) put_word(random_coeff());
    end

    drain();
    repeat (50) @(negedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("ntt_polynomial_convolution_top verification clean");
    end else begin
      $display("ntt_polynomial_convolution_top verification failed");
    end
    $finish;
  end

endmodule

### files.f
hdl/ntt_conv_pkg.sv
hdl/ntt_polynomial_convolution_top.sv
test/tb_ntt_conv_regs_pkg.sv
test/ntt_conv_checker.sv
test/tb_ntt_polynomial_convolution_top.sv
